FILE: src/ihex_pkg.sv
package ihex_pkg;

  // input command codes
  typedef enum logic {
    CmdChar = 1'b0,
    CmdEol  = 1'b1
  } ihex_cmd_e;

  // result kinds
  typedef enum logic {
    KindData    = 1'b0,
    KindSummary = 1'b1
  } ihex_kind_e;

  localparam logic [7:0] ColonChar  = 8'h3A;
  localparam logic [9:0] MinLineLen = 10'd11;
  localparam logic [9:0] PosMax     = 10'd1023;
  localparam int unsigned QueueDepth = 2;

  // classified character, passed from the front to the back
  typedef struct packed {
    ihex_cmd_e  cmd;
    logic       is_colon;
    logic       hex_ok;
    logic [3:0] nibble;
  } ihex_item_t;

  // one result transaction
  typedef struct packed {
    ihex_kind_e  kind;
    logic [7:0]  data_byte;
    logic [15:0] byte_address;
    logic        line_valid;
    logic [7:0]  record_type;
    logic [7:0]  byte_count;
  } ihex_result_t;

endpackage

FILE: src/ihex_front.sv
module ihex_front (
  input  logic              eol_i,
  input  logic [7:0]        char_i,
  output ihex_pkg::ihex_item_t item_o
);
  import ihex_pkg::*;

  logic [3:0] nib;
  logic       ok;

  // strict hex digit decode
  always_comb begin
    ok  = 1'b1;
    nib = 4'd0;
    if (char_i >= 8'h30 && char_i <= 8'h39) begin
      nib = char_i[3:0];
    end else if ((char_i >= 8'h41 && char_i <= 8'h46) ||
                 (char_i >= 8'h61 && char_i <= 8'h66)) begin
      nib = char_i[3:0] + 4'd9;
    end else begin
      ok = 1'b0;
    end
  end

  // classified item
  always_comb begin
    item_o.cmd      = eol_i ? CmdEol : CmdChar;
    item_o.is_colon = (char_i == ColonChar);
    item_o.hex_ok   = ok;
    item_o.nibble   = nib;
  end

endmodule

FILE: src/ihex_queue.sv
module ihex_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_valid_i,
  output logic                 push_ready_o,
  input  ihex_pkg::ihex_item_t push_item_i,
  output logic                 pop_valid_o,
  input  logic                 pop_ready_i,
  output ihex_pkg::ihex_item_t pop_item_o
);
  import ihex_pkg::*;

  ihex_item_t entry_q [QueueDepth];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       push, pop;

  assign push_ready_o = (count_q != 2'(QueueDepth));
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_item_o   = entry_q[rd_ptr_q];
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

FILE: src/ihex_back.sv
module ihex_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   item_valid_i,
  output logic                   item_ready_o,
  input  ihex_pkg::ihex_item_t   item_i,
  output logic                   res_valid_o,
  input  logic                   res_ready_i,
  output ihex_pkg::ihex_result_t res_o
);
  import ihex_pkg::*;

  logic [9:0]   pos_q, pos_d;
  logic [3:0]   hi_nib_q, hi_nib_d;
  logic [7:0]   rec_len_q, rec_len_d;
  logic [15:0]  start_addr_q, start_addr_d;
  logic [7:0]   type_q, type_d;
  logic [7:0]   sum_q, sum_d;
  logic [7:0]   data_idx_q, data_idx_d;
  logic [7:0]   csum_q, csum_d;
  logic         err_q, err_d;
  logic         out_valid_q, out_valid_d;
  ihex_result_t out_q, out_d;

  logic         take;
  logic         produced;
  logic [9:0]   last_pos;
  logic [9:0]   needed;
  logic [7:0]   byte_val;
  logic [9:0]   byte_idx;
  logic         line_ok;

  assign take         = item_valid_i && (!out_valid_q || res_ready_i);
  assign item_ready_o = !out_valid_q || res_ready_i;
  assign res_valid_o  = out_valid_q;
  assign res_o        = out_q;

  assign last_pos = 10'd10 + {1'b0, rec_len_q, 1'b0};
  assign needed   = MinLineLen + {1'b0, rec_len_q, 1'b0};
  assign byte_val = {hi_nib_q, item_i.nibble};
  assign byte_idx = {1'b0, pos_q[9:1]} - 10'd1;
  assign line_ok  = !err_q && (pos_q >= needed) && (sum_q == 8'd0);

  // record state update and result build
  always_comb begin
    pos_d        = pos_q;
    hi_nib_d     = hi_nib_q;
    rec_len_d    = rec_len_q;
    start_addr_d = start_addr_q;
    type_d       = type_q;
    sum_d        = sum_q;
    data_idx_d   = data_idx_q;
    csum_d       = csum_q;
    err_d        = err_q;
    produced     = 1'b0;
    out_d        = out_q;
    if (take) begin
      if (item_i.cmd == CmdEol) begin
        // end of line: summary, then clear for the next record
        produced           = 1'b1;
        out_d.kind         = KindSummary;
        out_d.data_byte    = 8'd0;
        out_d.byte_address = start_addr_q;
        out_d.line_valid   = line_ok;
        out_d.record_type  = type_q;
        out_d.byte_count   = data_idx_q;
        pos_d        = 10'd0;
        hi_nib_d     = 4'd0;
        rec_len_d    = 8'd0;
        start_addr_d = 16'd0;
        type_d       = 8'd0;
        sum_d        = 8'd0;
        data_idx_d   = 8'd0;
        csum_d       = 8'd0;
        err_d        = 1'b0;
      end else begin
        if (pos_q == 10'd0) begin
          if (!item_i.is_colon) begin
            err_d = 1'b1;
          end
        end else if (pos_q <= last_pos) begin
          if (!item_i.hex_ok) begin
            err_d = 1'b1;
          end
          if (pos_q[0]) begin
            hi_nib_d = item_i.nibble;
          end else begin
            sum_d = sum_q + byte_val;
            case (byte_idx)
              10'd0: rec_len_d = byte_val;
              10'd1: start_addr_d = {byte_val, start_addr_q[7:0]};
              10'd2: start_addr_d = {start_addr_q[15:8], byte_val};
              10'd3: type_d = byte_val;
              default: begin
                if ((byte_idx - 10'd4) < {2'b00, rec_len_q}) begin
                  produced           = 1'b1;
                  out_d.kind         = KindData;
                  out_d.data_byte    = byte_val;
                  out_d.byte_address = start_addr_q + {8'd0, data_idx_q};
                  out_d.line_valid   = 1'b0;
                  out_d.record_type  = 8'd0;
                  out_d.byte_count   = 8'd0;
                  data_idx_d         = data_idx_q + 8'd1;
                end else begin
                  csum_d = byte_val;
                end
              end
            endcase
          end
        end
        pos_d = (pos_q < PosMax) ? pos_q + 10'd1 : PosMax;
      end
    end
  end

  // output register holds a result until the receiver takes it
  assign out_valid_d = take ? produced : (out_valid_q && !res_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= 10'd0;
      hi_nib_q     <= 4'd0;
      rec_len_q    <= 8'd0;
      start_addr_q <= 16'd0;
      type_q       <= 8'd0;
      sum_q        <= 8'd0;
      data_idx_q   <= 8'd0;
      csum_q       <= 8'd0;
      err_q        <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      pos_q        <= pos_d;
      hi_nib_q     <= hi_nib_d;
      rec_len_q    <= rec_len_d;
      start_addr_q <= start_addr_d;
      type_q       <= type_d;
      sum_q        <= sum_d;
      data_idx_q   <= data_idx_d;
      csum_q       <= csum_d;
      err_q        <= err_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

endmodule

FILE: src/intel_hex_record_parser.sv
// Intel HEX record parser.
// The slave stream takes one transaction per line character; tuser = 1
// marks end of line (the character is then ignored). The master stream
// gives a tentative data byte for every decoded data pair (tuser = 0) and
// one line summary per end of line (tuser = 1) carrying validity, record
// type, start address and byte count.
// Throughput: one character per cycle while the master side is ready. A
// front stage decodes each character into a nibble and class, a two-entry
// queue decouples it from the back stage, which updates the record state
// and loads the output register in the same cycle.
// With the queue empty, an accepted character is first stored in the queue
// entry and its result then in the output register, which drives the master side.
// Reset clears the record state, the queue and the output valid flag; the
// next character is taken as the first of a new line.
// When the receiver stalls, the result holds in the output register, the
// back stage stops and the queue fills; tready drops once it is full.
module intel_hex_record_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] character
  input  logic        s_axis_tuser_i,   // [0] command
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o,   // [7:0] data_byte, [23:8] byte_address,
                                        // [24] line_valid, [32:25] record_type,
                                        // [40:33] byte_count, [47:41] zero
  output logic        m_axis_tuser_o    // [0] result_kind
);
  import ihex_pkg::*;

  ihex_item_t   front_item;
  ihex_item_t   queue_item;
  logic         queue_valid;
  logic         back_ready;
  ihex_result_t result;

  // character classification
  ihex_front u_front (
    .eol_i  (s_axis_tuser_i),
    .char_i (s_axis_tdata_i),
    .item_o (front_item)
  );

  // decoupling queue
  ihex_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (s_axis_tvalid_i),
    .push_ready_o (s_axis_tready_o),
    .push_item_i  (front_item),
    .pop_valid_o  (queue_valid),
    .pop_ready_i  (back_ready),
    .pop_item_o   (queue_item)
  );

  // record state and results
  ihex_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (queue_valid),
    .item_ready_o (back_ready),
    .item_i       (queue_item),
    .res_valid_o  (m_axis_tvalid_o),
    .res_ready_i  (m_axis_tready_i),
    .res_o        (result)
  );

  // output packing
  assign m_axis_tuser_o = result.kind;
  assign m_axis_tdata_o = {7'd0, result.byte_count, result.record_type, result.line_valid,
                           result.byte_address, result.data_byte};

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import ihex_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned MaxReports = 10;
  localparam int unsigned RandomChars = 420;

  // record decoder model and store of expected results
  class ihex_scoreboard;
    logic [9:0]   pos;
    logic [3:0]   hi_nib;
    logic [7:0]   rec_len;
    logic [15:0]  base_addr;
    logic [7:0]   rec_type;
    logic [7:0]   sum;
    logic [7:0]   n_data;
    logic         bad_line;
    ihex_result_t expected_q[$];
    int unsigned  mismatches;

    function new();
      mismatches = 0;
      clear_line();
    endfunction

    function void clear_line();
      pos       = '0;
      hi_nib    = '0;
      rec_len   = '0;
      base_addr = '0;
      rec_type  = '0;
      sum       = '0;
      n_data    = '0;
      bad_line  = 1'b0;
    endfunction

    function bit is_hex(logic [7:0] ch);
      return (ch >= "0" && ch <= "9") || (ch >= "A" && ch <= "F") || (ch >= "a" && ch <= "f");
    endfunction

    function logic [3:0] nibble_of(logic [7:0] ch);
      logic [7:0] v;
      v = 8'h00;
      if (ch >= "0" && ch <= "9") v = ch - "0";
      else if (ch >= "A" && ch <= "F") v = ch - "A" + 8'd10;
      else if (ch >= "a" && ch <= "f") v = ch - "a" + 8'd10;
      return v[3:0];
    endfunction

    // advance the record state by one accepted transaction
    function void note_char(ihex_cmd_e cmd, logic [7:0] ch);
      ihex_result_t res;
      logic [7:0]   byte_v;
      int           idx;
      res = '0;
      if (cmd == CmdEol) begin
        res.kind         = KindSummary;
        res.byte_address = base_addr;
        res.line_valid   = !bad_line && (int'(pos) >= int'(MinLineLen) + 2 * int'(rec_len))
                           && (sum == 8'h00);
        res.record_type  = rec_type;
        res.byte_count   = n_data;
        expected_q.push_back(res);
        clear_line();
        return;
      end
      if (pos == '0) begin
        if (ch != ColonChar) bad_line = 1'b1;
      end else if (int'(pos) <= 10 + 2 * int'(rec_len)) begin
        if (!is_hex(ch)) bad_line = 1'b1;
        if (pos[0]) begin
          hi_nib = nibble_of(ch);
        end else begin
          byte_v = {hi_nib, nibble_of(ch)};
          idx    = int'(pos) / 2 - 1;
          sum    = sum + byte_v;
          case (idx)
            0: rec_len = byte_v;
            1: base_addr[15:8] = byte_v;
            2: base_addr[7:0] = byte_v;
            3: rec_type = byte_v;
            default: begin
              // data bytes go out at once, the checksum pair only feeds the sum
              if (idx - 4 < int'(rec_len)) begin
                res.kind         = KindData;
                res.data_byte    = byte_v;
                res.byte_address = base_addr + 16'(n_data);
                expected_q.push_back(res);
                n_data = n_data + 8'd1;
              end
            end
          endcase
        end
      end
      if (pos != PosMax) pos = pos + 10'd1;
    endfunction

    // compare one accepted result against the oldest expectation
    function void check_result(logic kind, logic [47:0] tdata);
      ihex_result_t got;
      ihex_result_t want;
      got.kind         = ihex_kind_e'(kind);
      got.data_byte    = tdata[7:0];
      got.byte_address = tdata[23:8];
      got.line_valid   = tdata[24];
      got.record_type  = tdata[32:25];
      got.byte_count   = tdata[40:33];
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("unexpected result: kind %0d tdata %012h", kind, tdata);
        return;
      end
      want = expected_q.pop_front();
      if (got !== want || tdata[47:41] !== 7'd0) begin
        mismatches++;
        if (mismatches <= MaxReports) begin
          $display("mismatch: expected kind %0d data %02h addr %04h valid %0d",
                   want.kind, want.data_byte, want.byte_address, want.line_valid,
                   " type %02h count %0d", want.record_type, want.byte_count);
          $display("          actual   kind %0d data %02h addr %04h valid %0d",
                   got.kind, got.data_byte, got.byte_address, got.line_valid,
                   " type %02h count %0d pad %02h",
                   got.record_type, got.byte_count, tdata[47:41]);
        end
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_valid = 1'b0;
  logic [7:0]  s_data = 8'h00;
  logic        s_user = 1'b0;
  logic        m_ready = 1'b0;
  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [47:0] m_axis_tdata_o;
  logic        m_axis_tuser_o;

  ihex_scoreboard sb = new();
  logic [7:0]     rec_chars[$];
  int unsigned    chars_sent = 0;
  int unsigned    cycles = 0;
  bit             tx_idle_on = 1'b1;
  bit             rx_idle_on = 1'b1;

  intel_hex_record_parser u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  // clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic logic [7:0] hex_char(logic [3:0] n);
    if (n < 4'd10) return "0" + 8'(n);
    return ($urandom_range(0, 1) ? "a" : "A") + 8'(n) - 8'd10;
  endfunction

  function automatic void push_byte(logic [7:0] b);
    rec_chars.push_back(hex_char(b[7:4]));
    rec_chars.push_back(hex_char(b[3:0]));
  endfunction

  // assemble one record line with random data bytes
  function automatic void build_record(int len, logic [15:0] addr, logic [7:0] typ,
                                      bit sum_ok);
    logic [7:0] total;
    logic [7:0] b;
    rec_chars.delete();
    rec_chars.push_back(ColonChar);
    total = 8'(len) + addr[15:8] + addr[7:0] + typ;
    push_byte(8'(len));
    push_byte(addr[15:8]);
    push_byte(addr[7:0]);
    push_byte(typ);
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom_range(0, 255));
      total += b;
      push_byte(b);
    end
    if (sum_ok) push_byte(-total);
    else push_byte(-total + 8'($urandom_range(1, 255)));
  endfunction

  function automatic void add_trailing(int n);
    for (int i = 0; i < n; i++) rec_chars.push_back(8'($urandom_range(0, 255)));
  endfunction

  // one transaction on the slave side, with a random gap in front
  task automatic send_item(ihex_cmd_e cmd, logic [7:0] ch);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= ch;
    s_user  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_char(cmd, ch);
    chars_sent++;
    if ($urandom_range(0, 49) == 0) tx_idle_on = !tx_idle_on;
  endtask

  task automatic send_line();
    foreach (rec_chars[i]) send_item(CmdChar, rec_chars[i]);
    send_item(CmdEol, 8'($urandom_range(0, 255)));
  endtask

  // receiver with random stalls
  initial begin
    int stall;
    @(posedge rst_ni);
    forever begin
      stall = rx_idle_on ? $urandom_range(0, 14) : 0;
      if (stall > 0) begin
        m_ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_ready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
      sb.check_result(m_axis_tuser_o, m_axis_tdata_o);
      if ($urandom_range(0, 29) == 0) rx_idle_on = !rx_idle_on;
    end
  end

  // stimulus
  initial begin
    int         pick;
    int         len;
    int         at;
    logic [7:0] ch;
    bit         drain_done;
    drain_done = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty line
    rec_chars.delete();
    send_line();
    // end-of-file record
    build_record(0, 16'h0000, 8'h01, 1'b1);
    send_line();
    // address wrap at the top, extreme characters as trailing junk
    build_record(2, 16'hFFFF, 8'hFF, 1'b1);
    rec_chars.push_back(8'h00);
    rec_chars.push_back(8'hFF);
    send_line();
    // checksum wrong by a random nonzero amount
    build_record(1, 16'h1234, 8'h00, 1'b0);
    send_line();
    // non-hex digit inside the address
    build_record(1, 16'hABCD, 8'h00, 1'b1);
    rec_chars[4] = "G";
    send_line();
    // short line
    build_record(3, 16'h8000, 8'h00, 1'b1);
    rec_chars = rec_chars[0:4];
    send_line();
    // colon missing
    build_record(1, 16'h0100, 8'h00, 1'b1);
    rec_chars[0] = "0";
    send_line();

    // random lines, mostly well formed
    chars_sent = 0;
    while (chars_sent < RandomChars) begin
      pick = $urandom_range(0, 99);
      len  = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 8);
      build_record(len, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 5)),
                   !(pick >= 60 && pick < 70));
      if (pick < 60) begin
        if ($urandom_range(0, 4) == 0) add_trailing($urandom_range(1, 6));
      end else if (pick < 78 && pick >= 70) begin
        rec_chars = rec_chars[0:$urandom_range(0, rec_chars.size() - 2)];
      end else if (pick < 86 && pick >= 78) begin
        at = $urandom_range(1, rec_chars.size() - 1);
        do ch = 8'($urandom_range(0, 255)); while (sb.is_hex(ch));
        rec_chars[at] = ch;
      end else if (pick < 91 && pick >= 86) begin
        do ch = 8'($urandom_range(0, 255)); while (ch == ColonChar);
        rec_chars[0] = ch;
      end else if (pick < 96 && pick >= 91) begin
        rec_chars.delete();
        add_trailing($urandom_range(0, 20));
      end else if (pick >= 96) begin
        rec_chars.delete();
      end
      send_line();

      // once past the halfway mark, hold the sender until every result is back
      if (!drain_done && chars_sent > RandomChars / 2) begin
        drain_done = 1'b1;
        s_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge clk_i);
      end
    end
    s_valid <= 1'b0;

    // drain and finish
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
